>>> sv/wsfr_pkg.sv
// ----------------------------------------------------------------------------
// wsfr_pkg
// Shared types and constants for the frame receiver: parser phases, result
// status codes and the item passed from the header parser to the output side.
// ----------------------------------------------------------------------------
package wsfr_pkg;

  // Parser phase of the byte stream
  typedef enum logic [2:0] {
    PH_HDR0    = 3'd0,
    PH_HDR1    = 3'd1,
    PH_EXT0    = 3'd2,
    PH_EXT1    = 3'd3,
    PH_KEY     = 3'd4,
    PH_PAYLOAD = 3'd5
  } phase_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_DATA    = 2'd0,
    ST_LEN127  = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_MASKERR = 2'd3
  } status_t;

  // 7-bit length codes that select the extended length forms
  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;

  // Classified item: raw byte plus the key byte that unmasks it
  typedef struct packed {
    status_t     status;
    logic [7:0]  data;
    logic [7:0]  key;
    logic        fin;
    logic [3:0]  opcode;
    logic        last;
  } item_t;

endpackage

>>> sv/wsfr_front.sv
// ----------------------------------------------------------------------------
// wsfr_front
// Header parser: walks the frame header, captures length and masking key,
// and classifies each accepted byte into a payload item, an error item or
// nothing.
// ----------------------------------------------------------------------------
module wsfr_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic [7:0]           in_byte,
  input  logic                 cfg_wr_en,
  input  logic                 cfg_wr_data,
  output logic                 q_push,
  output wsfr_pkg::item_t      q_item
);

  wsfr_pkg::phase_t phase_r, phase_nxt;
  logic             fin_r, fin_nxt;
  logic [3:0]       opcode_r, opcode_nxt;
  logic             masked_r, masked_nxt;
  logic [7:0]       len_hi_r, len_hi_nxt;
  logic [15:0]      remaining_r, remaining_nxt;
  logic [31:0]      key_r, key_nxt;
  logic [1:0]       key_idx_r, key_idx_nxt;
  logic             expect_masked_r;

  logic [6:0]       len7;
  logic             mbit;
  logic [15:0]      ext_len;
  logic             last;
  logic             mask_bad;
  logic [7:0]       key_byte;

  assign len7     = in_byte[6:0];
  assign mbit     = in_byte[7];
  assign ext_len  = {len_hi_r, in_byte};
  assign last     = (remaining_r <= 16'd1);
  assign mask_bad = (mbit != expect_masked_r);

  // Select key byte for the current payload offset, first key byte first
  always_comb begin
    case (key_idx_r)
      2'd0:    key_byte = key_r[31:24];
      2'd1:    key_byte = key_r[23:16];
      2'd2:    key_byte = key_r[15:8];
      default: key_byte = key_r[7:0];
    endcase
  end

  // Next phase
  always_comb begin
    phase_nxt = phase_r;
    if (in_valid) begin
      unique case (phase_r)
        wsfr_pkg::PH_HDR1: begin
          if (len7 == wsfr_pkg::LEN_EXT64 || mask_bad || len7 == 7'd0)
            phase_nxt = wsfr_pkg::PH_HDR0;
          else if (len7 == wsfr_pkg::LEN_EXT16)
            phase_nxt = wsfr_pkg::PH_EXT0;
          else
            phase_nxt = mbit ? wsfr_pkg::PH_KEY : wsfr_pkg::PH_PAYLOAD;
        end
        wsfr_pkg::PH_EXT0: phase_nxt = wsfr_pkg::PH_EXT1;
        wsfr_pkg::PH_EXT1: begin
          if (ext_len == 16'd0)
            phase_nxt = wsfr_pkg::PH_HDR0;
          else
            phase_nxt = masked_r ? wsfr_pkg::PH_KEY : wsfr_pkg::PH_PAYLOAD;
        end
        wsfr_pkg::PH_KEY: begin
          if (key_idx_r == 2'd3) phase_nxt = wsfr_pkg::PH_PAYLOAD;
        end
        wsfr_pkg::PH_PAYLOAD: begin
          if (last) phase_nxt = wsfr_pkg::PH_HDR0;
        end
        default: phase_nxt = wsfr_pkg::PH_HDR1;
      endcase
    end
  end

  // Outputs: classify the accepted byte
  always_comb begin
    q_push        = 1'b0;
    q_item.status = wsfr_pkg::ST_DATA;
    q_item.data   = 8'd0;
    q_item.key    = 8'd0;
    q_item.fin    = fin_r;
    q_item.opcode = opcode_r;
    q_item.last   = 1'b0;
    if (in_valid) begin
      unique case (phase_r)
        wsfr_pkg::PH_HDR1: begin
          if (len7 == wsfr_pkg::LEN_EXT64) begin
            q_push        = 1'b1;
            q_item.status = wsfr_pkg::ST_LEN127;
          end else if (mask_bad) begin
            q_push        = 1'b1;
            q_item.status = wsfr_pkg::ST_MASKERR;
          end else if (len7 == 7'd0) begin
            q_push        = 1'b1;
            q_item.status = wsfr_pkg::ST_EMPTY;
          end
        end
        wsfr_pkg::PH_EXT1: begin
          if (ext_len == 16'd0) begin
            q_push        = 1'b1;
            q_item.status = wsfr_pkg::ST_EMPTY;
          end
        end
        wsfr_pkg::PH_PAYLOAD: begin
          q_push      = 1'b1;
          q_item.data = in_byte;
          q_item.key  = masked_r ? key_byte : 8'd0;
          q_item.last = last;
        end
        default: q_push = 1'b0;
      endcase
    end
  end

  // Frame context updates
  always_comb begin
    fin_nxt       = fin_r;
    opcode_nxt    = opcode_r;
    masked_nxt    = masked_r;
    len_hi_nxt    = len_hi_r;
    remaining_nxt = remaining_r;
    key_nxt       = key_r;
    key_idx_nxt   = key_idx_r;
    if (in_valid) begin
      unique case (phase_r)
        wsfr_pkg::PH_HDR1: begin
          masked_nxt    = mbit;
          remaining_nxt = {9'd0, len7};
          key_idx_nxt   = 2'd0;
        end
        wsfr_pkg::PH_EXT0: len_hi_nxt = in_byte;
        wsfr_pkg::PH_EXT1: begin
          remaining_nxt = ext_len;
          key_idx_nxt   = 2'd0;
        end
        wsfr_pkg::PH_KEY: begin
          key_nxt     = {key_r[23:0], in_byte};
          key_idx_nxt = key_idx_r + 2'd1;
        end
        wsfr_pkg::PH_PAYLOAD: begin
          key_idx_nxt   = key_idx_r + 2'd1;
          remaining_nxt = last ? 16'd0 : remaining_r - 16'd1;
        end
        default: begin
          fin_nxt    = in_byte[7];
          opcode_nxt = in_byte[3:0];
        end
      endcase
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r         <= wsfr_pkg::PH_HDR0;
      fin_r           <= 1'b0;
      opcode_r        <= 4'd0;
      masked_r        <= 1'b0;
      len_hi_r        <= 8'd0;
      remaining_r     <= 16'd0;
      key_r           <= 32'd0;
      key_idx_r       <= 2'd0;
      expect_masked_r <= 1'b1;
    end else begin
      phase_r     <= phase_nxt;
      fin_r       <= fin_nxt;
      opcode_r    <= opcode_nxt;
      masked_r    <= masked_nxt;
      len_hi_r    <= len_hi_nxt;
      remaining_r <= remaining_nxt;
      key_r       <= key_nxt;
      key_idx_r   <= key_idx_nxt;
      if (cfg_wr_en) expect_masked_r <= cfg_wr_data;
    end
  end

  // The final payload byte or any error sends the parser back to header
  a_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
    q_push && (q_item.last || q_item.status != wsfr_pkg::ST_DATA)
      |=> phase_r == wsfr_pkg::PH_HDR0)
    else $error("parser did not return to header after frame end");

  // Payload items only come from the payload phase
  a_data_phase: assert property (@(posedge clk) disable iff (!rst_n)
    q_push && q_item.status == wsfr_pkg::ST_DATA |-> phase_r == wsfr_pkg::PH_PAYLOAD)
    else $error("payload item outside payload phase");

endmodule

>>> sv/wsfr_queue.sv
// ----------------------------------------------------------------------------
// wsfr_queue
// Short first-in first-out queue of classified items between the header
// parser and the output stage.
// ----------------------------------------------------------------------------
module wsfr_queue #(
  parameter int DEPTH = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_en,
  input  wsfr_pkg::item_t      wr_item,
  input  logic                 rd_en,
  output wsfr_pkg::item_t      rd_item,
  output logic                 full,
  output logic                 empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  wsfr_pkg::item_t   slot_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign rd_item = slot_r[rd_ptr_r];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (wr_en)
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    if (rd_en)
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    if (wr_en && !rd_en)
      count_nxt = count_r + 1'b1;
    else if (rd_en && !wr_en)
      count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store written item
  always_ff @(posedge clk) begin
    if (wr_en) slot_r[wr_ptr_r] <= wr_item;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> !full)
    else $error("write into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |-> !empty)
    else $error("read from empty queue");

endmodule

>>> sv/wsfr_back.sv
// ----------------------------------------------------------------------------
// wsfr_back
// Output stage: takes classified items from the queue, removes the mask from
// payload bytes and holds the result in an output register until popped.
// ----------------------------------------------------------------------------
module wsfr_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_empty,
  input  wsfr_pkg::item_t      q_item,
  output logic                 q_pop,
  input  logic                 pop,
  output logic                 empty,
  output logic [1:0]           out_status,
  output logic [7:0]           out_data_byte,
  output logic                 out_fin,
  output logic [3:0]           out_opcode,
  output logic                 out_last_in_frame
);

  logic            valid_r, valid_nxt;
  wsfr_pkg::item_t res_r;
  wsfr_pkg::item_t load_item;

  // Load when the output register is free or being emptied this cycle
  assign q_pop = !q_empty && (!valid_r || pop);

  always_comb begin
    valid_nxt = valid_r;
    if (q_pop)
      valid_nxt = 1'b1;
    else if (pop)
      valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= 1'b0;
    else        valid_r <= valid_nxt;
  end

  // Unmask payload byte on load
  always_comb begin
    load_item      = q_item;
    load_item.data = q_item.data ^ q_item.key;
    load_item.key  = 8'd0;
  end

  always_ff @(posedge clk) begin
    if (q_pop) res_r <= load_item;
  end

  assign empty             = !valid_r;
  assign out_status        = res_r.status;
  assign out_data_byte     = res_r.data;
  assign out_fin           = res_r.fin;
  assign out_opcode        = res_r.opcode;
  assign out_last_in_frame = res_r.last;

  // A waiting result is not overwritten while the receiver stalls
  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && !pop |=> valid_r && $stable(res_r))
    else $error("pending result changed while stalled");

endmodule

>>> sv/websocket_frame_receiver.sv
// ----------------------------------------------------------------------------
// websocket_frame_receiver
// Frame deframer with payload unmasking for a received byte stream.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: drive in_byte and push; a byte is taken on a clock edge
//   with push high and full low. Header, extended length and key bytes give
//   no result; each payload byte gives one result, and a frame with a 127
//   length code, a zero length or an unexpected mask bit gives one error
//   result, after which parsing restarts at the next header byte.
//   Result channel: while empty is low the oldest result is on the out_
//   ports; it is taken on a clock edge with pop high.
//   Throughput: one byte per cycle while full is low. Each result's item
//   is written into the item queue at the edge that takes its byte and is
//   moved to the output register once that register is free or being popped.
//   Stalls: results back up into the output register and then the item
//   queue (QUEUE_DEPTH entries); full rises once that queue fills, holding
//   off further bytes, including those that give no result.
//   Reset (rst_n low, synchronous): parser back to the first header byte,
//   queue and output register emptied, mask expectation set to masked.
//   cfg_wr_en/cfg_wr_data write the expect-masked register; write it only
//   while no frame is in progress and no result is pending.
// ----------------------------------------------------------------------------
module websocket_frame_receiver #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [7:0]  in_byte,
  input  logic        push,
  output logic        full,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  out_status,
  output logic [7:0]  out_data_byte,
  output logic        out_fin,
  output logic [3:0]  out_opcode,
  output logic        out_last_in_frame,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data
);

  logic            in_valid;
  logic            q_push;
  wsfr_pkg::item_t q_wr_item;
  wsfr_pkg::item_t q_rd_item;
  logic            q_pop;
  logic            q_empty;

  assign in_valid = push && !full;

  // Parse and classify
  wsfr_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_byte     (in_byte),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .q_push      (q_push),
    .q_item      (q_wr_item)
  );

  // Decouple parser from output stage
  wsfr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_push),
    .wr_item (q_wr_item),
    .rd_en   (q_pop),
    .rd_item (q_rd_item),
    .full    (full),
    .empty   (q_empty)
  );

  // Unmask and present results
  wsfr_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_empty           (q_empty),
    .q_item            (q_rd_item),
    .q_pop             (q_pop),
    .pop               (pop),
    .empty             (empty),
    .out_status        (out_status),
    .out_data_byte     (out_data_byte),
    .out_fin           (out_fin),
    .out_opcode        (out_opcode),
    .out_last_in_frame (out_last_in_frame)
  );

endmodule
